[rtl/bpa_pkg.sv]
package bpa_pkg;

  localparam int MAX_PAGES  = 1024;
  localparam int NUM_ORDERS = 10;
  localparam int REF_BITS   = 16;

  localparam int PW  = $clog2(MAX_PAGES);
  localparam int LW  = PW + 1;
  localparam int OW  = 4;
  localparam int OIW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
  localparam int CW  = 11;

  localparam logic [LW-1:0]       NIL     = LW'(MAX_PAGES);
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  typedef enum logic [1:0] {
    RQ_ALLOC   = 2'd0,
    RQ_ADD     = 2'd1,
    RQ_RELEASE = 2'd2,
    RQ_SEED    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PAGES = 2'd1,
    ST_BAD_ARG  = 2'd2,
    ST_REF_ERR  = 2'd3
  } status_e;

  typedef struct packed {
    logic [OW-1:0]       order;
    logic                in_use;
    logic                on_list;
    logic [REF_BITS-1:0] refs;
  } attr_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_RES_PRE, OP_ALLOC_FIND, OP_SET_OP_HEAD,
    OP_SET_OP_IDX, OP_SET_OP_BUD, OP_SET_OP_FREE, OP_SPLIT_DOWN, OP_RM_RD,
    OP_RM_WR, OP_PU_RD, OP_PU_WR, OP_PU_LINK, OP_ATTR_RD_OP, OP_ATTR_RD_PG,
    OP_ALLOC_FIN, OP_EVAL, OP_MERGE_RD, OP_MERGE_UP, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_alloc;
    logic alloc_bad;
    logic alloc_none;
    logic idx_bad;
    logic split_more;
    logic need_free;
    logic link_needed;
    logic merge_cand;
    logic merge_ok;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/bpa_req_if.sv]
interface bpa_req_if;
  import bpa_pkg::*;
  logic          valid;
  logic          ready;
  req_e          req_type;
  logic [OW-1:0] req_order;
  logic [PW-1:0] page_idx;

  modport source (output valid, req_type, req_order, page_idx, input ready);
  modport sink (input valid, req_type, req_order, page_idx, output ready);
endinterface

[rtl/bpa_res_if.sv]
interface bpa_res_if;
  import bpa_pkg::*;
  logic                valid;
  logic                ready;
  status_e             status;
  logic [PW-1:0]       result_page;
  logic [REF_BITS-1:0] result_refcount;
  logic [CW-1:0]       free_pages;

  modport source (output valid, status, result_page, result_refcount, free_pages,
                  input ready);
  modport sink (input valid, status, result_page, result_refcount, free_pages,
                output ready);
endinterface

[rtl/bpa_ctrl.sv]
module bpa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bpa_pkg::dp_stat_t  stat_i,
  output bpa_pkg::dp_cmd_t   cmd_o
);
  import bpa_pkg::*;

  typedef enum logic [19:0] {
    S_CLEAR    = 20'd1 << 0,
    S_IDLE     = 20'd1 << 1,
    S_DISPATCH = 20'd1 << 2,
    S_SPLIT    = 20'd1 << 3,
    S_SPLIT2   = 20'd1 << 4,
    S_SPLIT3   = 20'd1 << 5,
    S_TAKE     = 20'd1 << 6,
    S_TAKE2    = 20'd1 << 7,
    S_EVAL     = 20'd1 << 8,
    S_MFREE    = 20'd1 << 9,
    S_MCHK     = 20'd1 << 10,
    S_MCHK2    = 20'd1 << 11,
    S_MRM2     = 20'd1 << 12,
    S_MUP      = 20'd1 << 13,
    S_DONE     = 20'd1 << 14,
    S_RM0      = 20'd1 << 15,
    S_RM1      = 20'd1 << 16,
    S_PU0      = 20'd1 << 17,
    S_PU1      = 20'd1 << 18,
    S_PU2      = 20'd1 << 19
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // List removal and insertion are shared subroutines; ret_q holds the caller's next state.
  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.is_alloc) begin
          if (stat_i.alloc_bad || stat_i.alloc_none) begin
            cmd_o.op = OP_RES_PRE;
            state_d  = S_DONE;
          end else begin
            cmd_o.op = OP_ALLOC_FIND;
            state_d  = S_SPLIT;
          end
        end else if (stat_i.idx_bad) begin
          cmd_o.op = OP_RES_PRE;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_ATTR_RD_PG;
          state_d  = S_EVAL;
        end
      end
      S_SPLIT: begin
        cmd_o.op = OP_SET_OP_HEAD;
        state_d  = S_RM0;
        ret_d    = stat_i.split_more ? S_SPLIT2 : S_TAKE;
      end
      S_SPLIT2: begin
        cmd_o.op = OP_SPLIT_DOWN;
        state_d  = S_PU0;
        ret_d    = S_SPLIT3;
      end
      S_SPLIT3: begin
        cmd_o.op = OP_SET_OP_BUD;
        state_d  = S_PU0;
        ret_d    = S_SPLIT;
      end
      S_TAKE: begin
        cmd_o.op = OP_ATTR_RD_OP;
        state_d  = S_TAKE2;
      end
      S_TAKE2: begin
        cmd_o.op = OP_ALLOC_FIN;
        state_d  = S_DONE;
      end
      S_EVAL: begin
        cmd_o.op = OP_EVAL;
        state_d  = stat_i.need_free ? S_MFREE : S_DONE;
      end
      S_MFREE: begin
        cmd_o.op = OP_SET_OP_FREE;
        state_d  = S_PU0;
        ret_d    = S_MCHK;
      end
      S_MCHK: begin
        if (stat_i.merge_cand) begin
          cmd_o.op = OP_MERGE_RD;
          state_d  = S_MCHK2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MCHK2: begin
        if (stat_i.merge_ok) begin
          cmd_o.op = OP_SET_OP_IDX;
          state_d  = S_RM0;
          ret_d    = S_MRM2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MRM2: begin
        cmd_o.op = OP_SET_OP_BUD;
        state_d  = S_RM0;
        ret_d    = S_MUP;
      end
      S_MUP: begin
        cmd_o.op = OP_MERGE_UP;
        state_d  = S_PU0;
        ret_d    = S_MCHK;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      S_RM0: begin
        cmd_o.op = OP_RM_RD;
        state_d  = S_RM1;
      end
      S_RM1: begin
        cmd_o.op = OP_RM_WR;
        state_d  = ret_q;
      end
      S_PU0: begin
        cmd_o.op = OP_PU_RD;
        state_d  = S_PU1;
      end
      S_PU1: begin
        cmd_o.op = OP_PU_WR;
        state_d  = stat_i.link_needed ? S_PU2 : ret_q;
      end
      S_PU2: begin
        cmd_o.op = OP_PU_LINK;
        state_d  = ret_q;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[rtl/bpa_datapath.sv]
module bpa_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bpa_pkg::dp_cmd_t        cmd_i,
  output bpa_pkg::dp_stat_t       stat_o,
  input  logic [bpa_pkg::CW-1:0]  limit_i,
  bpa_req_if.sink                 req,
  bpa_res_if.source               res
);
  import bpa_pkg::*;

  attr_t         attr_mem [MAX_PAGES];
  logic [LW-1:0] next_mem [MAX_PAGES];
  logic [LW-1:0] prev_mem [MAX_PAGES];

  logic [LW-1:0] head_q [NUM_ORDERS];
  logic [LW-1:0] tail_q [NUM_ORDERS];

  req_e                req_type_q;
  logic [OW-1:0]       req_ord_q, ord_q, op_o_q;
  logic [PW-1:0]       req_pg_q, idx_q, bud_q, op_p_q, tail_old_q, clr_cnt_q;
  logic                clr_inuse_q;
  attr_t               attr_q;
  logic [LW-1:0]       next_rd_q, prev_rd_q;
  logic [CW-1:0]       avail_q;
  status_e             res_status_q;
  logic [PW-1:0]       res_page_q;
  logic [REF_BITS-1:0] res_ref_q;
  logic                out_valid_q;

  logic                attr_we, next_we, prev_we, attr_re;
  logic [PW-1:0]       attr_wa, next_wa, prev_wa, attr_ra;
  attr_t               attr_wd;
  logic [LW-1:0]       next_wd, prev_wd;

  logic [OW-1:0]       found;
  logic                none_found;
  logic                rm_ok, pu_new;
  logic [LW-1:0]       tail_cur;
  logic [PW-1:0]       bud_c;
  logic [OW-1:0]       ord_up;
  status_e             ev_status;
  logic [REF_BITS-1:0] ev_ref;
  logic                ev_write, ev_free;

  assign tail_cur = tail_q[op_o_q[OIW-1:0]];
  assign rm_ok    = attr_q.on_list && (attr_q.order == op_o_q);
  assign pu_new   = !attr_q.on_list;
  assign bud_c    = idx_q ^ (PW'(1) << ord_q);
  assign ord_up   = ord_q + OW'(1);

  always_comb begin
    found      = '0;
    none_found = 1'b1;
    for (int o = NUM_ORDERS - 1; o >= 0; o--) begin
      if (head_q[o] != NIL && OW'(o) >= req_ord_q) begin
        found      = OW'(o);
        none_found = 1'b0;
      end
    end
  end

  // Outcome of add, release and seed once the page's attributes have been read.
  always_comb begin
    ev_status = ST_OK;
    ev_ref    = attr_q.refs;
    ev_write  = 1'b0;
    ev_free   = 1'b0;
    case (req_type_q)
      RQ_ADD: begin
        if (attr_q.refs == '0 || attr_q.refs == REF_MAX) begin
          ev_status = ST_REF_ERR;
        end else begin
          ev_ref   = attr_q.refs + REF_BITS'(1);
          ev_write = 1'b1;
        end
      end
      RQ_RELEASE: begin
        if (attr_q.refs == '0) begin
          ev_status = ST_REF_ERR;
        end else begin
          ev_ref   = attr_q.refs - REF_BITS'(1);
          ev_write = 1'b1;
          ev_free  = (ev_ref == '0) && ({1'b0, attr_q.order} < (OW+1)'(NUM_ORDERS));
        end
      end
      RQ_SEED: begin
        if (!attr_q.in_use || attr_q.on_list) begin
          ev_status = ST_BAD_ARG;
        end else if (attr_q.refs != '0) begin
          ev_status = ST_REF_ERR;
        end else begin
          ev_free = 1'b1;
        end
      end
      default: ev_status = ST_OK;
    endcase
  end

  always_comb begin
    attr_we = 1'b0;
    attr_wa = op_p_q;
    attr_wd = attr_q;
    next_we = 1'b0;
    next_wa = op_p_q;
    next_wd = NIL;
    prev_we = 1'b0;
    prev_wa = op_p_q;
    prev_wd = tail_cur;
    attr_re = 1'b0;
    attr_ra = op_p_q;
    case (cmd_i.op)
      OP_CLEAR: begin
        attr_we = 1'b1;
        attr_wa = clr_cnt_q;
        attr_wd = '{order: '0, in_use: 1'b1, on_list: 1'b0, refs: '0};
      end
      OP_RM_RD, OP_PU_RD, OP_ATTR_RD_OP: attr_re = 1'b1;
      OP_ATTR_RD_PG: begin
        attr_re = 1'b1;
        attr_ra = req_pg_q;
      end
      OP_MERGE_RD: begin
        attr_re = 1'b1;
        attr_ra = bud_c;
      end
      OP_RM_WR: begin
        attr_we         = rm_ok;
        attr_wd.on_list = 1'b0;
        next_we         = rm_ok && (prev_rd_q != NIL);
        next_wa         = prev_rd_q[PW-1:0];
        next_wd         = next_rd_q;
        prev_we         = rm_ok && (next_rd_q != NIL);
        prev_wa         = next_rd_q[PW-1:0];
        prev_wd         = prev_rd_q;
      end
      OP_PU_WR: begin
        attr_we         = 1'b1;
        attr_wd.order   = op_o_q;
        attr_wd.on_list = 1'b1;
        attr_wd.in_use  = clr_inuse_q ? 1'b0 : attr_q.in_use;
        next_we         = pu_new;
        prev_we         = pu_new;
      end
      OP_PU_LINK: begin
        next_we = 1'b1;
        next_wa = tail_old_q;
        next_wd = {1'b0, op_p_q};
      end
      OP_ALLOC_FIN: begin
        attr_we        = 1'b1;
        attr_wd.in_use = 1'b1;
        attr_wd.refs   = REF_BITS'(1);
      end
      OP_EVAL: begin
        attr_we      = ev_write;
        attr_wa      = req_pg_q;
        attr_wd.refs = ev_ref;
      end
      default: attr_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (attr_we) attr_mem[attr_wa] <= attr_wd;
    if (attr_re) attr_q <= attr_mem[attr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (cmd_i.op == OP_RM_RD) next_rd_q <= next_mem[op_p_q];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (cmd_i.op == OP_RM_RD) prev_rd_q <= prev_mem[op_p_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int o = 0; o < NUM_ORDERS; o++) begin
        head_q[o] <= NIL;
        tail_q[o] <= NIL;
      end
      avail_q     <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new beat may replace the one taken at this same edge.
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CLEAR: clr_cnt_q <= clr_cnt_q + PW'(1);
        OP_RM_WR: begin
          if (rm_ok && prev_rd_q == NIL) head_q[op_o_q[OIW-1:0]] <= next_rd_q;
          if (rm_ok && next_rd_q == NIL) tail_q[op_o_q[OIW-1:0]] <= prev_rd_q;
        end
        OP_PU_WR: begin
          if (pu_new) begin
            tail_q[op_o_q[OIW-1:0]] <= {1'b0, op_p_q};
            if (tail_cur == NIL) head_q[op_o_q[OIW-1:0]] <= {1'b0, op_p_q};
          end
        end
        OP_ALLOC_FIN: avail_q <= avail_q - (CW'(1) << req_ord_q);
        OP_EVAL: begin
          if (ev_free && req_type_q == RQ_RELEASE) begin
            avail_q <= avail_q + (CW'(1) << attr_q.order);
          end else if (ev_free) begin
            avail_q <= avail_q + CW'(1);
          end
        end
        default: avail_q <= avail_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        req_type_q <= req.req_type;
        req_ord_q  <= req.req_order;
        req_pg_q   <= req.page_idx;
      end
      OP_RES_PRE: begin
        res_status_q <= (req_type_q == RQ_ALLOC && !stat_o.alloc_bad) ? ST_NO_PAGES
                                                                      : ST_BAD_ARG;
        res_page_q   <= (req_type_q == RQ_ALLOC) ? '0 : req_pg_q;
        res_ref_q    <= '0;
      end
      OP_ALLOC_FIND: ord_q <= found;
      OP_SET_OP_HEAD: begin
        op_o_q      <= ord_q;
        op_p_q      <= head_q[ord_q[OIW-1:0]][PW-1:0];
        clr_inuse_q <= 1'b0;
      end
      OP_SET_OP_IDX: begin
        op_o_q      <= ord_q;
        op_p_q      <= idx_q;
        clr_inuse_q <= 1'b0;
      end
      OP_SET_OP_FREE: begin
        op_o_q      <= ord_q;
        op_p_q      <= idx_q;
        clr_inuse_q <= 1'b1;
      end
      OP_SET_OP_BUD: begin
        op_o_q      <= ord_q;
        op_p_q      <= bud_q;
        clr_inuse_q <= 1'b0;
      end
      OP_SPLIT_DOWN: begin
        ord_q       <= ord_q - OW'(1);
        op_o_q      <= ord_q - OW'(1);
        idx_q       <= op_p_q;
        bud_q       <= op_p_q ^ (PW'(1) << (ord_q - OW'(1)));
        clr_inuse_q <= 1'b0;
      end
      OP_PU_WR: tail_old_q <= tail_cur[PW-1:0];
      OP_ALLOC_FIN: begin
        res_status_q <= ST_OK;
        res_page_q   <= op_p_q;
        res_ref_q    <= REF_BITS'(1);
      end
      OP_EVAL: begin
        res_status_q <= ev_status;
        res_page_q   <= req_pg_q;
        res_ref_q    <= ev_ref;
        ord_q        <= (req_type_q == RQ_SEED) ? '0 : attr_q.order;
        idx_q        <= req_pg_q;
      end
      OP_MERGE_RD: bud_q <= bud_c;
      OP_MERGE_UP: begin
        ord_q       <= ord_up;
        op_o_q      <= ord_up;
        idx_q       <= idx_q & ~((PW'(1) << ord_up) - PW'(1));
        op_p_q      <= idx_q & ~((PW'(1) << ord_up) - PW'(1));
        clr_inuse_q <= 1'b0;
      end
      OP_EMIT: begin
        res.status          <= res_status_q;
        res.result_page     <= res_page_q;
        res.result_refcount <= res_ref_q;
        res.free_pages      <= avail_q;
      end
      default: idx_q <= idx_q;
    endcase
  end

  assign res.valid = out_valid_q;

  always_comb begin
    stat_o.clr_done    = (clr_cnt_q == PW'(MAX_PAGES - 1));
    stat_o.is_alloc    = (req_type_q == RQ_ALLOC);
    stat_o.alloc_bad   = ({1'b0, req_ord_q} >= (OW+1)'(NUM_ORDERS));
    stat_o.alloc_none  = none_found;
    stat_o.idx_bad     = (CW'(req_pg_q) >= limit_i);
    stat_o.split_more  = (ord_q > req_ord_q);
    stat_o.need_free   = ev_free;
    stat_o.link_needed = pu_new && (tail_cur != NIL);
    stat_o.merge_cand  = ({1'b0, ord_q} + (OW+1)'(1) < (OW+1)'(NUM_ORDERS))
                         && (CW'(bud_c) < limit_i);
    stat_o.merge_ok    = !attr_q.in_use && attr_q.on_list && (attr_q.order == ord_q);
    stat_o.out_free    = !out_valid_q || res.ready;
  end

endmodule

[rtl/buddy_page_allocator.sv]
// Channel | Dir | Beat contents
// req_i   | in  | req_type, req_order, page_idx
// res_o   | out | status, result_page, result_refcount, free_pages
// APB     | in  | pages_in_zone at byte address 0
//
// One request at a time. A rejected request, an add or a release that frees nothing goes
// straight to its result; a freeing release or seed puts the page on a free list and walks
// the lists again for each merge, and allocate walks them for each split. The list walks
// through the attribute and link memories set the pace of each request.
// After reset a clearing pass initializes the attributes of every page; req_i is
// not ready during it. A finished beat waits in the output register while a new
// request is already accepted; the next result stalls until res_o takes it.
module buddy_page_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpa_req_if.sink     req_i,
  bpa_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bpa_pkg::*;

  logic [CW-1:0] limit_q;
  dp_cmd_t       cmd;
  dp_stat_t      stat;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : 32'(limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= CW'(MAX_PAGES);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      limit_q <= pwdata[CW-1:0];
    end
  end

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bpa_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .limit_i (limit_q),
    .req     (req_i),
    .res     (res_o)
  );

endmodule

[rtl/bpa_checker.sv]
module bpa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input bpa_pkg::status_e             out_status,
  input logic [bpa_pkg::PW-1:0]       out_page,
  input logic [bpa_pkg::REF_BITS-1:0] out_ref,
  input logic [bpa_pkg::CW-1:0]       out_free
);
  import bpa_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_free <= CW'(MAX_PAGES))
    else $error("free page count out of range");

  a_no_pages_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status == ST_NO_PAGES |-> out_page == '0 && out_ref == '0)
    else $error("failed allocate reports a page");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (req_i.valid),
  .in_ready   (req_i.ready),
  .out_valid  (res_o.valid),
  .out_ready  (res_o.ready),
  .out_status (res_o.status),
  .out_page   (res_o.result_page),
  .out_ref    (res_o.result_refcount),
  .out_free   (res_o.free_pages)
);
